// ===== src/asdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asdc_pkg;

	// Default widths of the signed sample and of each color channel.
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COLOR_WIDTH_DEF  = 16;

	// Input command codes, carried in bit 0 of the input tuser.
	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_MAP  = 1'b1;

	// Control from the stream front end to the arithmetic core.
	typedef struct packed {
		logic start;
		logic ack;
	} asdc_ctl_t;

	// Status from the arithmetic core back to the front end.
	typedef struct packed {
		logic idle;
		logic done;
	} asdc_sts_t;

endpackage

`default_nettype wire

// ===== src/asdc_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared subtract-and-compare unit used by the divider and the square root steps.
module asdc_alu #(
	parameter int W = 20
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] diff,
	output logic              ge
);

	logic [W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[W-1:0];
	assign ge   = ~full[W];

endmodule

`default_nettype wire

// ===== src/asdc_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared multiplier with a registered product.
module asdc_mul #(
	parameter int W = 20
) (
	input  wire logic           clk,
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   b,
	output logic      [2*W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= (2*W)'(a) * (2*W)'(b);
	end

endmodule

`default_nettype wire

// ===== src/asdc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asdc_core
	import asdc_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COLOR_WIDTH  = COLOR_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire asdc_ctl_t               ctl,
	input  wire logic [SAMPLE_WIDTH-1:0] mag,
	input  wire logic                    neg,
	input  wire logic [SAMPLE_WIDTH-1:0] peak,
	output asdc_sts_t                    sts,
	output logic      [COLOR_WIDTH-1:0]  red,
	output logic      [COLOR_WIDTH-1:0]  green,
	output logic      [COLOR_WIDTH-1:0]  blue,
	output logic                         zero_peak
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int F     = COLOR_WIDTH;
	localparam int AW    = (SW + 1 > F + 4) ? SW + 1 : F + 4;
	localparam int MW    = F + 4;
	localparam int CNT_W = $clog2(F + 1);
	localparam int WW    = 2 * F + 5;
	// Reciprocal of 5 scaled by 2^(F+6); exact floor for any dividend below 2^(F+3).
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << (F + 6)) + 64'd4) / 64'd5);
	localparam logic [F+2:0]  RED_LIMIT = (F+3)'(5) << F;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CAP  = 4'd1;
	localparam logic [3:0] ST_DIV  = 4'd2;
	localparam logic [3:0] ST_SQRT = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_FIN  = 4'd5;
	localparam logic [3:0] ST_RMUL = 4'd6;
	localparam logic [3:0] ST_RFIN = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW:0]      rem_q;
	logic [SW-1:0]    div_q;
	logic             neg_q;
	logic [F+1:0]     q_q;
	logic [2*F+1:0]   xs_q;
	logic [F+1:0]     rr_q;
	logic [F:0]       res_q;
	logic [F+2:0]     u_q;
	logic             usat_q;
	logic [F-1:0]     red_q;
	logic [F-1:0]     green_q;
	logic [F-1:0]     blue_q;
	logic             zp_q;

	logic [AW-1:0]    alu_a;
	logic [AW-1:0]    alu_b;
	logic [AW-1:0]    alu_diff;
	logic             alu_ge;
	logic [MW-1:0]    mul_a;
	logic [MW-1:0]    mul_b;
	logic [2*MW-1:0]  mul_p;

	logic [F+1:0]     q_next;
	logic [SW-1:0]    rem_next;
	logic [F+3:0]     sq_shift;
	logic [2*F+2:0]   q2;
	logic [WW-1:0]    t7;
	logic [WW-1:0]    g3;
	logic [F+2:0]     u_next;
	logic [F+2:0]     g_neg;
	logic [F+2:0]     g_pos;
	logic [F-1:0]     s_sat;

	asdc_alu #(.W(AW)) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	asdc_mul #(.W(MW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Operand selection for the shared compare unit.
	assign sq_shift = {rr_q, xs_q[2*F+1:2*F]};
	always_comb begin
		unique case (state_q)
			ST_CAP: begin
				alu_a = AW'(rem_q);
				alu_b = AW'({div_q, 1'b0});
			end
			ST_SQRT: begin
				alu_a = AW'(sq_shift);
				alu_b = AW'({res_q, 2'b01});
			end
			default: begin
				alu_a = AW'(rem_q);
				alu_b = AW'(div_q);
			end
		endcase
	end

	assign mul_a = (state_q == ST_RMUL) ? MW'(u_q) : MW'(q_q);
	assign mul_b = (state_q == ST_RMUL) ? RECIP : MW'(q_q);

	assign q_next   = {q_q[F:0], alu_ge};
	assign rem_next = alu_ge ? alu_diff[SW-1:0] : rem_q[SW-1:0];

	// Channel terms formed from q squared and the square root.
	assign q2     = mul_p[2*F+2:0];
	assign t7     = (WW'(q2) << 3) - WW'(q2);
	assign g3     = (WW'(q2) << 1) + WW'(q2) + (WW'(res_q) << F);
	assign u_next = t7[2*F+4:F+2];
	assign g_neg  = g3[2*F+4:F+2];
	assign g_pos  = q2[2*F+2:F];
	assign s_sat  = res_q[F] ? {F{1'b1}} : res_q[F-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= (peak == '0) ? ST_DONE : ST_CAP;
					end
				end
				ST_CAP: begin
					state_q <= alu_ge ? ST_SQRT : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_FIN;
				ST_FIN:  state_q <= neg_q ? ST_RMUL : ST_DONE;
				ST_RMUL: state_q <= ST_RFIN;
				ST_RFIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (ctl.ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rem_q   <= (SW+1)'(mag);
				div_q   <= peak;
				neg_q   <= neg;
				zp_q    <= (peak == '0);
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end
			ST_CAP: begin
				cnt_q <= CNT_W'(F);
				rr_q  <= '0;
				res_q <= '0;
				if (alu_ge) begin
					// The quotient is at least two: clamp it, every live channel saturates anyway.
					q_q  <= (F+2)'(1) << (F + 1);
					xs_q <= {(F+2)'(1) << (F + 1), {F{1'b0}}};
				end else begin
					q_q <= '0;
				end
			end
			ST_DIV: begin
				q_q   <= q_next;
				rem_q <= {rem_next, 1'b0};
				xs_q  <= {q_next, {F{1'b0}}};
				cnt_q <= (cnt_q == '0) ? CNT_W'(F) : cnt_q - 1'b1;
			end
			ST_SQRT: begin
				xs_q  <= xs_q << 2;
				rr_q  <= alu_ge ? alu_diff[F+1:0] : sq_shift[F+1:0];
				res_q <= {res_q[F-1:0], alu_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_FIN: begin
				u_q    <= u_next;
				usat_q <= (u_next >= RED_LIMIT);
				if (neg_q) begin
					green_q <= (|g_neg[F+2:F]) ? {F{1'b1}} : g_neg[F-1:0];
					blue_q  <= s_sat;
				end else begin
					red_q   <= s_sat;
					green_q <= (|g_pos[F+2:F]) ? {F{1'b1}} : g_pos[F-1:0];
					blue_q  <= '0;
				end
			end
			ST_RFIN: begin
				red_q <= usat_q ? {F{1'b1}} : mul_p[F+6 +: F];
			end
			default: begin
			end
		endcase
	end

	assign sts.idle  = (state_q == ST_IDLE);
	assign sts.done  = (state_q == ST_DONE);
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign zero_peak = zp_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> sts.idle)
		else $error("core started while busy");

	a_zero_peak_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.start && peak == '0) |=> (sts.done && zero_peak))
		else $error("zero peak did not finish at once");

	a_ack_done: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.done && ctl.ack) |=> sts.idle)
		else $error("core did not return to idle after hand-off");
`endif

endmodule

`default_nettype wire

// ===== src/auto_scaled_diverging_colormap.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Diverging colormap with automatic peak scaling. A frame of signed samples is
// streamed in twice. During the scan pass (tuser bit 0 low) the block keeps the
// peak magnitude of the frame; tuser bit 1 marks the first sample and restarts the
// peak. Scan transactions produce no output and are taken one per clock while the
// core is idle. During the map pass (tuser bit 0 high) every sample is divided by
// the peak and turned into red, green and blue in unsigned Q0.COLOR_WIDTH:
// positive values run from black through yellow, negative values through blue,
// and channels saturate at full scale. If the peak is zero the color is black and
// tuser of the output is set. A mapped sample holds the input off until the core
// hands its color to the output register: a range check, a bit-per-cycle restoring
// divide and a bit-per-cycle square root, both running on a single shared
// subtract-and-compare unit, squaring on one shared multiplier, a reciprocal
// multiply for a negative sample, and the hand-off. A sample at or beyond twice
// the peak skips the divide. A zero-peak map goes straight to the hand-off. The
// input is not ready while the core works; a finished color sits in the output
// register so the next sample can be taken while the downstream side stalls.
module auto_scaled_diverging_colormap
	import asdc_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COLOR_WIDTH  = COLOR_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// tdata: sample, then zero padding to whole bytes.
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	// tuser: bit 0 command, bit 1 first.
	input  wire logic [1:0]                            s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// tdata: red, green, blue from the lowest bit up, then zero padding.
	output logic      [((3*COLOR_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
	// tuser: bit 0 zero_peak.
	output logic      [0:0]                            m_axis_tuser
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int F     = COLOR_WIDTH;
	localparam int OUT_W = ((3 * F + 7) / 8) * 8;

	asdc_ctl_t        ctl;
	asdc_sts_t        sts;
	logic [SW-1:0]    sample;
	logic             sample_neg;
	logic [SW-1:0]    mag;
	logic [SW-1:0]    peak_q;
	logic             in_acc;
	logic             is_map;
	logic             out_load;
	logic [F-1:0]     red;
	logic [F-1:0]     green;
	logic [F-1:0]     blue;
	logic             zero_peak;
	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;
	logic             m_user_q;

	assign sample     = s_axis_tdata[SW-1:0];
	assign sample_neg = sample[SW-1];
	// Two's complement negation; the most negative sample becomes 2^(SW-1) unsigned.
	assign mag        = sample_neg ? (~sample + 1'b1) : sample;

	assign s_axis_tready = sts.idle;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_map        = (s_axis_tuser[0] == CMD_MAP);

	// Peak tracking on scan transactions; a first flag restarts it at this sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (in_acc && !is_map) begin
			if (s_axis_tuser[1] || (mag > peak_q)) begin
				peak_q <= mag;
			end
		end
	end

	assign ctl.start = in_acc && is_map;
	assign out_load  = sts.done && (!m_valid_q || m_axis_tready);
	assign ctl.ack   = out_load;

	asdc_core #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COLOR_WIDTH  (COLOR_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.mag       (mag),
		.neg       (sample_neg),
		.peak      (peak_q),
		.sts       (sts),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.zero_peak (zero_peak)
	);

	// Output register decouples the core from downstream back-pressure.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= OUT_W'({blue, green, red});
			m_user_q <= zero_peak;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_user_q;

`ifndef SYNTH
	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_map) |=> !s_axis_tready)
		else $error("input still ready after a map transaction");

	a_first_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !is_map && s_axis_tuser[1]) |=> (peak_q == $past(mag)))
		else $error("first scan sample did not restart the peak");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_axis_tready) |-> !out_load)
		else $error("pending output overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Checks the peak-scaled diverging colormap end to end over its stream ports.
// Every scan taken on the input updates a local copy of the peak, and every
// map taken queues the color the block must produce. A checker on the
// output side compares each result with the oldest queued color. The sender
// works in random bursts and the receiver stalls in changing patterns.
module testbench;
	import asdc_pkg::*;

	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int CW          = COLOR_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 100;
	localparam int SHOW_LIMIT  = 10;

	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
		logic          zero_peak;
	} rgb_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	wire                             s_axis_tready;
	logic [((SW+7)/8)*8-1:0]         s_axis_tdata  = '0;
	logic [1:0]                      s_axis_tuser  = '0;
	wire                             m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	wire  [((3*CW+7)/8)*8-1:0]       m_axis_tdata;
	wire  [0:0]                      m_axis_tuser;

	// Colors still owed by the block, oldest first.
	rgb_t        pending_colors[$];
	// Local copy of the peak magnitude; it can reach 2^(SW-1).
	logic [SW:0] peak_level = '0;
	int          mismatch_count = 0;
	int          burst_left = 0;
	longint      cycle_count = 0;

	auto_scaled_diverging_colormap u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned sqrt_floor(input longint unsigned x);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [CW-1:0] clip_color(input longint unsigned x);
		return (x > 64'((1 << CW) - 1)) ? {CW{1'b1}} : x[CW-1:0];
	endfunction

	// Color of one mapped sample under the given peak, truncating at every step.
	function automatic rgb_t predict_color(input logic [SW-1:0] smp, input logic [SW:0] pk);
		rgb_t            c;
		logic            neg;
		longint unsigned mag;
		longint unsigned q;
		longint unsigned q2;
		longint unsigned root;
		c = '0;
		neg = smp[SW-1];
		mag = neg ? (64'd1 << SW) - 64'(smp) : 64'(smp);
		if (pk == 0) begin
			c.zero_peak = 1'b1;
		end else if (mag != 0) begin
			q = (mag << CW) / 64'(pk);
			// Beyond twice the peak every live channel is saturated anyway.
			if (q > (64'd1 << (CW + 1)))
				q = 64'd1 << (CW + 1);
			q2 = q * q;
			root = sqrt_floor(q << CW);
			if (!neg) begin
				c.red   = clip_color(root);
				c.green = clip_color(q2 >> CW);
			end else begin
				c.red   = clip_color((64'd7 * q2) / (64'd20 << CW));
				c.green = clip_color((64'd3 * q2 + (root << CW)) >> (CW + 2));
				c.blue  = clip_color(root);
			end
		end
		return c;
	endfunction

	// Sign-extended random value that spans w bits.
	function automatic logic [SW-1:0] random_sample(input int w);
		logic signed [SW-1:0] x;
		x = SW'($urandom);
		return x >>> (SW - w);
	endfunction

	// Offers one transaction and returns at the edge that takes it. Gaps only
	// open between bursts, so valid is never lowered and raised in one step.
	task automatic send_item(input logic cmd, input logic [SW-1:0] smp, input logic first_flag);
		int   gap;
		logic [SW:0] mag;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(5, 20);
				default: gap = $urandom_range(0, 3);
			endcase
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= {first_flag, cmd};
		do @(posedge clk); while (!s_axis_tready);

		if (cmd == CMD_SCAN) begin
			mag = smp[SW-1] ? (SW+1)'(1 << SW) - {1'b0, smp} : {1'b0, smp};
			if (first_flag)
				peak_level = '0;
			if (mag > peak_level)
				peak_level = mag;
		end else begin
			pending_colors.push_back(predict_color(smp, peak_level));
		end
	endtask

	// Holds the input off until every queued color has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_colors.size() != 0)
			@(posedge clk);
	endtask

	// Maps issued before any scan, while the peak is still zero after reset.
	task automatic test_zero_peak();
		send_item(CMD_MAP, 16'h7FFF, 1'b0);
		send_item(CMD_MAP, 16'hFFFF, 1'b1);
	endtask

	// A full-scale frame: the most negative sample sets the peak, then the
	// extremes and small values on both sides are mapped.
	task automatic test_full_scale();
		send_item(CMD_SCAN, 16'h8000, 1'b1);
		send_item(CMD_SCAN, 16'd100, 1'b0);
		send_item(CMD_MAP, 16'h7FFF, 1'b0);
		send_item(CMD_MAP, 16'h8000, 1'b0);
		send_item(CMD_MAP, 16'h0000, 1'b0);
		send_item(CMD_MAP, 16'h0001, 1'b0);
		send_item(CMD_MAP, 16'hFFFF, 1'b0);
		send_item(CMD_MAP, 16'h4000, 1'b0);
		send_item(CMD_MAP, 16'hC000, 1'b0);
	endtask

	// A tiny peak so that the extreme samples lie far beyond it and saturate. A first flag
	// on a map must leave the peak alone. The frame ends with an all-zero scan.
	task automatic test_small_peak();
		send_item(CMD_SCAN, 16'd3, 1'b1);
		send_item(CMD_SCAN, 16'hFFFE, 1'b0);
		send_item(CMD_MAP, 16'd3, 1'b0);
		send_item(CMD_MAP, 16'hFFFD, 1'b0);
		send_item(CMD_MAP, 16'h7FFF, 1'b0);
		send_item(CMD_MAP, 16'h8000, 1'b0);
		send_item(CMD_MAP, 16'd1, 1'b0);
		send_item(CMD_MAP, 16'hFFFF, 1'b0);
		send_item(CMD_MAP, 16'd2, 1'b1);
		send_item(CMD_MAP, 16'd3, 1'b0);
		send_item(CMD_SCAN, 16'd0, 1'b1);
		send_item(CMD_MAP, 16'd5, 1'b0);
	endtask

	// Frames of random content and amplitude, each scanned then mapped, with a
	// share of broken frames: missing or stray first flags, skipped map passes,
	// samples beyond the peak and scans slipped into the map pass.
	task automatic test_random_frames(input int target);
		logic [SW-1:0] frame_vals[$];
		int            sent;
		int            frames;
		int            len;
		int            kind;
		int            w;
		logic          fl;
		sent = 0;
		frames = 0;
		while (sent < target) begin
			frame_vals.delete();
			len = $urandom_range(1, 24);
			kind = $urandom_range(0, 15);
			w = (kind < 6) ? SW : $urandom_range(1, SW - 1);
			for (int i = 0; i < len; i++)
				frame_vals.push_back((kind == 15) ? '0 : random_sample(w));

			for (int i = 0; i < len; i++) begin
				fl = (i == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 31) == 0);
				send_item(CMD_SCAN, frame_vals[i], fl);
			end
			sent += len;

			if ($urandom_range(0, 9) != 0) begin
				for (int i = 0; i < len; i++) begin
					fl = ($urandom_range(0, 7) == 0);
					case ($urandom_range(0, 19))
						0, 1: send_item(CMD_MAP, random_sample(SW), fl);
						2: begin
							send_item(CMD_SCAN, random_sample(w), 1'b0);
							send_item(CMD_MAP, frame_vals[i], fl);
							sent++;
						end
						default: send_item(CMD_MAP, frame_vals[i], fl);
					endcase
				end
				sent += len;
			end

			frames++;
			if (frames % 8 == 0)
				wait_drained();
		end
	endtask

	// Output checker. Values are sampled at the edge, before anything driven
	// at that edge takes effect.
	always @(posedge clk) begin
		rgb_t got;
		rgb_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.red       = m_axis_tdata[CW-1:0];
			got.green     = m_axis_tdata[2*CW-1:CW];
			got.blue      = m_axis_tdata[3*CW-1:2*CW];
			got.zero_peak = m_axis_tuser[0];
			if (pending_colors.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_LIMIT)
					$display("%0t: unexpected color r=%h g=%h b=%h zp=%b", $realtime,
						got.red, got.green, got.blue, got.zero_peak);
			end else begin
				want = pending_colors.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_LIMIT)
						$display("%0t: color mismatch exp r=%h g=%h b=%h zp=%b, got r=%h g=%h b=%h zp=%b",
							$realtime, want.red, want.green, want.blue, want.zero_peak,
							got.red, got.green, got.blue, got.zero_peak);
				end
			end
		end
	end

	// Receiver backpressure: the pattern switches between always ready, random
	// stalls, a short duty cycle and long stalls.
	int stall_mode = 0;
	int mode_left  = 0;
	int phase      = 0;
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(64, 400);
		end
		mode_left--;
		phase++;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ((phase % 7) < 3);
			default: m_axis_tready <= ((phase % 37) == 0);
		endcase
	end

	// Guard against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_peak();
		test_full_scale();
		test_small_peak();
		wait_drained();
		test_random_frames(800);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		mismatch_count += pending_colors.size();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
